// ===== rtl/core/rmsd_pkg.sv =====
// rmsd_pkg: shared types and codes for the rgb matrix scan driver
// command codes, the queued command record and the result record
`timescale 1ns / 1ps

package rmsd_pkg;

	localparam logic [1:0] CMD_WRITE = 2'd0;
	localparam logic [1:0] CMD_CLEAR = 2'd1;
	localparam logic [1:0] CMD_SCAN  = 2'd2;

	localparam logic MODE_OFF = 1'b1;

	localparam int CMD_DEPTH = 4;
	localparam int OUT_DEPTH = 4;

	typedef enum logic [1:0] {
		OP_WRITE,
		OP_CLEAR,
		OP_SCAN,
		OP_DARK_SCAN
	} op_t;

	typedef struct packed {
		op_t        op;
		logic [3:0] row;
		logic [4:0] column;
		logic [2:0] color;
	} cmd_t;

	typedef struct packed {
		logic [2:0] top_rgb;
		logic [2:0] bottom_rgb;
		logic [2:0] row_address;
		logic       shift_strobe;
		logic       latch_strobe;
		logic       output_blank;
		logic       last_of_scan;
	} result_t;

endpackage

// ===== rtl/core/rmsd_front.sv =====
// rmsd_front: classifies accepted requests into back-end operations
// drops ignored pixel writes and unused codes; uses rmsd_pkg
`timescale 1ns / 1ps

module rmsd_front import rmsd_pkg::*; #(
	parameter int COLUMNS   = 32,
	parameter int SCAN_ROWS = 8
) (
	input  logic       display_mode,
	input  logic       accept,
	input  logic [1:0] command,
	input  logic [3:0] pixel_row,
	input  logic [4:0] pixel_column,
	input  logic [2:0] pixel_color,
	output logic       q_push,
	output cmd_t       q_data
);

	logic in_panel;

	assign in_panel = (32'(pixel_row) < 32'(2 * SCAN_ROWS)) &&
		(32'(pixel_column) < 32'(COLUMNS));

	always_comb begin
		q_push        = 1'b0;
		q_data.op     = OP_WRITE;
		q_data.row    = pixel_row;
		q_data.column = pixel_column;
		q_data.color  = pixel_color;
		unique case (command)
			CMD_WRITE: begin
				q_push = accept && (display_mode != MODE_OFF) && in_panel;
			end
			CMD_CLEAR: begin
				q_data.op = OP_CLEAR;
				q_push    = accept;
			end
			CMD_SCAN: begin
				// off mode clears the store before the scan
				q_data.op = (display_mode == MODE_OFF) ? OP_DARK_SCAN : OP_SCAN;
				q_push    = accept;
			end
			default: begin
				q_push = 1'b0;
			end
		endcase
	end

endmodule

// ===== rtl/core/rmsd_cmd_queue.sv =====
// rmsd_cmd_queue: short queue of classified operations between front and back
// uses rmsd_pkg for the operation record
`timescale 1ns / 1ps

module rmsd_cmd_queue import rmsd_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic push,
	input  cmd_t push_data,
	output logic full,
	input  logic pop,
	output logic empty,
	output cmd_t head
);

	localparam int QW = $clog2(CMD_DEPTH);

	cmd_t          entry_q [CMD_DEPTH];
	logic [QW-1:0] wr_ptr_q;
	logic [QW-1:0] rd_ptr_q;
	logic [QW:0]   count_q;
	logic          do_push;
	logic          do_pop;

	assign full    = (count_q == (QW+1)'(CMD_DEPTH));
	assign empty   = (count_q == '0);
	assign head    = entry_q[rd_ptr_q];
	assign do_push = push && !full;
	assign do_pop  = pop && !empty;

	always_ff @(posedge clk) begin
		if (do_push) begin
			entry_q[wr_ptr_q] <= push_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + 1'b1;
			end else if (do_pop && !do_push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

// ===== rtl/core/rmsd_back.sv =====
// rmsd_back: frame store banks, clear sweep, row scan sequencer and result queue
// top and bottom panel halves sit in separate banks; uses rmsd_pkg
`timescale 1ns / 1ps

module rmsd_back import rmsd_pkg::*; #(
	parameter int COLUMNS   = 32,
	parameter int SCAN_ROWS = 8
) (
	input  logic    clk,
	input  logic    arst_n,
	input  logic    q_empty,
	input  cmd_t    q_head,
	output logic    q_pop,
	output logic    init_busy,
	input  logic    pop,
	output logic    empty,
	output result_t head
);

	localparam int HALF = SCAN_ROWS * COLUMNS;
	localparam int AW   = $clog2(HALF);
	localparam int CW   = $clog2(COLUMNS);
	localparam int RW   = $clog2(SCAN_ROWS);
	localparam int OW   = $clog2(OUT_DEPTH);

	typedef enum logic [1:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_SCAN,
		ST_LATCH
	} state_t;

	state_t        state_q;
	logic          init_q;
	logic          scan_after_q;
	logic [AW-1:0] sweep_q;
	logic [CW-1:0] col_q;
	logic [RW-1:0] scan_row_q;

	logic          valid_s1;
	logic          latch_s1;
	logic [RW-1:0] row_s1;

	logic [2:0]    mem_top [HALF];
	logic [2:0]    mem_bot [HALF];
	logic [2:0]    rd_top_q;
	logic [2:0]    rd_bot_q;

	logic          we_top;
	logic          we_bot;
	logic [AW-1:0] waddr;
	logic [AW-1:0] raddr;
	logic [AW-1:0] pix_addr;
	logic [2:0]    wdata;
	logic          bottom;
	logic [RW-1:0] half_row;

	logic          room;
	logic          issue;

	result_t       fifo_q [OUT_DEPTH];
	logic [OW-1:0] wr_ptr_q;
	logic [OW-1:0] rd_ptr_q;
	logic [OW:0]   count_q;
	logic          push_out;
	logic          pop_out;
	result_t       item;

	assign init_busy = init_q;
	assign q_pop     = (state_q == ST_IDLE) && !q_empty;

	// pixel position to bank and address
	assign bottom   = 32'(q_head.row) >= 32'(SCAN_ROWS);
	assign half_row = bottom ? RW'(32'(q_head.row) - 32'(SCAN_ROWS)) : RW'(q_head.row);
	assign pix_addr = AW'(32'(half_row) * 32'(COLUMNS) + 32'(q_head.column));
	assign raddr    = AW'(32'(scan_row_q) * 32'(COLUMNS) + 32'(col_q));

	// keep one slot per read in flight so the pipeline never overruns the queue
	assign room  = (count_q + (OW+1)'(valid_s1)) < (OW+1)'(OUT_DEPTH);
	assign issue = room && ((state_q == ST_SCAN) || (state_q == ST_LATCH));

	always_comb begin
		we_top = 1'b0;
		we_bot = 1'b0;
		waddr  = pix_addr;
		wdata  = q_head.color;
		if (state_q == ST_CLEAR) begin
			we_top = 1'b1;
			we_bot = 1'b1;
			waddr  = sweep_q;
			wdata  = 3'd0;
		end else if (q_pop && (q_head.op == OP_WRITE)) begin
			we_top = !bottom;
			we_bot = bottom;
		end
	end

	always_ff @(posedge clk) begin
		if (we_top) begin
			mem_top[waddr] <= wdata;
		end
		rd_top_q <= mem_top[raddr];
	end

	always_ff @(posedge clk) begin
		if (we_bot) begin
			mem_bot[waddr] <= wdata;
		end
		rd_bot_q <= mem_bot[raddr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_CLEAR;
			init_q       <= 1'b1;
			scan_after_q <= 1'b0;
			sweep_q      <= '0;
			col_q        <= '0;
			scan_row_q   <= '0;
			valid_s1     <= 1'b0;
			latch_s1     <= 1'b0;
			row_s1       <= '0;
		end else begin
			valid_s1 <= issue;
			latch_s1 <= (state_q == ST_LATCH);
			row_s1   <= scan_row_q;
			unique case (state_q)
				ST_CLEAR: begin
					if (sweep_q == AW'(HALF - 1)) begin
						sweep_q      <= '0;
						init_q       <= 1'b0;
						scan_after_q <= 1'b0;
						state_q      <= scan_after_q ? ST_SCAN : ST_IDLE;
					end else begin
						sweep_q <= sweep_q + 1'b1;
					end
				end
				ST_IDLE: begin
					if (q_pop) begin
						unique case (q_head.op)
							OP_WRITE: begin
								state_q <= ST_IDLE;
							end
							OP_CLEAR: begin
								state_q <= ST_CLEAR;
							end
							OP_SCAN: begin
								state_q <= ST_SCAN;
							end
							OP_DARK_SCAN: begin
								state_q      <= ST_CLEAR;
								scan_after_q <= 1'b1;
							end
						endcase
					end
				end
				ST_SCAN: begin
					if (room) begin
						if (col_q == CW'(COLUMNS - 1)) begin
							col_q   <= '0;
							state_q <= ST_LATCH;
						end else begin
							col_q <= col_q + 1'b1;
						end
					end
				end
				ST_LATCH: begin
					if (room) begin
						scan_row_q <= (scan_row_q == RW'(SCAN_ROWS - 1)) ? '0 :
							scan_row_q + 1'b1;
						state_q    <= ST_IDLE;
					end
				end
			endcase
		end
	end

	always_comb begin
		item.top_rgb      = latch_s1 ? 3'd0 : rd_top_q;
		item.bottom_rgb   = latch_s1 ? 3'd0 : rd_bot_q;
		item.row_address  = 3'(row_s1);
		item.shift_strobe = !latch_s1;
		item.latch_strobe = latch_s1;
		item.output_blank = !latch_s1;
		item.last_of_scan = latch_s1;
	end

	assign push_out = valid_s1;
	assign pop_out  = pop && !empty;
	assign empty    = (count_q == '0);
	assign head     = fifo_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push_out) begin
			fifo_q[wr_ptr_q] <= item;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push_out) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (pop_out) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			if (push_out && !pop_out) begin
				count_q <= count_q + 1'b1;
			end else if (pop_out && !push_out) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

// ===== rtl/core/rgb_matrix_scan_driver_core.sv =====
// rgb_matrix_scan_driver_core: top level of the led panel scan driver
// instantiates rmsd_front, rmsd_cmd_queue and rmsd_back; uses rmsd_pkg
`timescale 1ns / 1ps

// Scan driver for a panel of 2*SCAN_ROWS rows by COLUMNS columns. Requests enter through a
// queue port (push/full) and panel pin items leave through another (pop/empty). A scan gives
// COLUMNS shift items and one latch item, one per cycle while results are popped steadily,
// the pace being set by the single read port of each half-panel store bank. A clear is
// dequeued and then sweeps the store one address a cycle; a scan in off mode runs that
// sweep first.
// After reset the same clearing pass runs with full held high;
// display_mode writes are taken at any time but must only be issued while the block is idle.

module rgb_matrix_scan_driver_core import rmsd_pkg::*; #(
	parameter int COLUMNS   = 32,
	parameter int SCAN_ROWS = 8
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       cfg_valid,
	output logic       cfg_ready,
	input  logic       cfg_data,
	input  logic       push,
	output logic       full,
	input  logic [1:0] command,
	input  logic [3:0] pixel_row,
	input  logic [4:0] pixel_column,
	input  logic [2:0] pixel_color,
	input  logic       pop,
	output logic       empty,
	output logic [2:0] top_rgb,
	output logic [2:0] bottom_rgb,
	output logic [2:0] row_address,
	output logic       shift_strobe,
	output logic       latch_strobe,
	output logic       output_blank,
	output logic       last_of_scan
);

	logic    display_mode_q;
	logic    accept;
	logic    q_push;
	cmd_t    q_data;
	logic    q_full;
	logic    q_pop;
	logic    q_empty;
	cmd_t    q_head;
	logic    init_busy;
	result_t head;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			display_mode_q <= 1'b0;
		end else if (cfg_valid && cfg_ready) begin
			display_mode_q <= cfg_data;
		end
	end

	// no request taken during the clearing pass after reset
	assign full   = q_full || init_busy;
	assign accept = push && !full;

	rmsd_front #(
		.COLUMNS   (COLUMNS),
		.SCAN_ROWS (SCAN_ROWS)
	) u_front (
		.display_mode (display_mode_q),
		.accept       (accept),
		.command      (command),
		.pixel_row    (pixel_row),
		.pixel_column (pixel_column),
		.pixel_color  (pixel_color),
		.q_push       (q_push),
		.q_data       (q_data)
	);

	rmsd_cmd_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (q_push),
		.push_data (q_data),
		.full      (q_full),
		.pop       (q_pop),
		.empty     (q_empty),
		.head      (q_head)
	);

	rmsd_back #(
		.COLUMNS   (COLUMNS),
		.SCAN_ROWS (SCAN_ROWS)
	) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.q_empty   (q_empty),
		.q_head    (q_head),
		.q_pop     (q_pop),
		.init_busy (init_busy),
		.pop       (pop),
		.empty     (empty),
		.head      (head)
	);

	assign top_rgb      = head.top_rgb;
	assign bottom_rgb   = head.bottom_rgb;
	assign row_address  = head.row_address;
	assign shift_strobe = head.shift_strobe;
	assign latch_strobe = head.latch_strobe;
	assign output_blank = head.output_blank;
	assign last_of_scan = head.last_of_scan;

endmodule

// ===== rtl/core/rmsd_checker.sv =====
// rmsd_checker: port-level checks on the scan driver result stream
// bound to rgb_matrix_scan_driver_core; no package dependency
`timescale 1ns / 1ps

module rmsd_checker (
	input logic       clk,
	input logic       arst_n,
	input logic       pop,
	input logic       empty,
	input logic [2:0] top_rgb,
	input logic [2:0] bottom_rgb,
	input logic [2:0] row_address,
	input logic       shift_strobe,
	input logic       latch_strobe,
	input logic       output_blank,
	input logic       last_of_scan
);

	// a result is either a blanked shift or the unblanking last latch
	a_item_kind: assert property (@(posedge clk) disable iff (!arst_n)
		!empty |-> (latch_strobe == last_of_scan) && (latch_strobe != shift_strobe) &&
			(output_blank == shift_strobe))
		else $error("result strobes inconsistent");

	a_latch_dark: assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && latch_strobe) |-> (top_rgb == 3'd0) && (bottom_rgb == 3'd0))
		else $error("latch item carries colour");

	// a shift is always followed by a result of the same row pair
	a_row_kept: assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && pop && shift_strobe) |=> (empty || (row_address == $past(row_address))))
		else $error("row address changed inside a scan");

	a_head_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && !pop) |=> (!empty && $stable(top_rgb) && $stable(bottom_rgb) &&
			$stable(row_address) && $stable(latch_strobe)))
		else $error("waiting result changed");

endmodule

bind rgb_matrix_scan_driver_core rmsd_checker u_rmsd_checker (.*);
